>>> rtl/core/keypad_code_lock_defines.svh
// Assertion macros for the keypad code lock.
// Used by the top level only; relies on clk and rst in the including scope.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

// same-cycle implication
`define KCL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/kcl_pkg.sv
// Shared constants and types for the keypad code lock.
// No dependencies; imported by kcl_cell and keypad_code_lock.
package kcl_pkg;

  localparam int KCL_MAX_SYMBOLS = 16;
  localparam int LEN_W = 5;
  localparam int SYM_W = 4;
  localparam int CODE_W = 64;

  localparam logic [7:0] SYM_LOW = 8'h2A;
  localparam logic [7:0] SYM_HIGH = 8'h39;
  localparam logic [7:0] CH_SUBMIT = 8'h3D;
  localparam logic [7:0] CH_CLEAR = 8'h7A;

  localparam logic [2:0] EV_IGNORED = 3'd0;
  localparam logic [2:0] EV_SYMBOL = 3'd1;
  localparam logic [2:0] EV_CLEARED = 3'd2;
  localparam logic [2:0] EV_WRONG = 3'd3;
  localparam logic [2:0] EV_OPENED = 3'd4;

  localparam logic [1:0] REG_CODE_SYMBOLS = 2'd0;
  localparam logic [1:0] REG_CODE_LENGTH = 2'd1;
  localparam logic [1:0] REG_FAILURE_LIMIT = 2'd2;

  localparam logic [CODE_W-1:0] CODE_RESET = 64'h987;
  localparam logic [LEN_W-1:0] CODE_LENGTH_RESET = 5'd3;
  localparam logic [3:0] FAILURE_LIMIT_RESET = 4'd3;
  localparam logic [3:0] FAIL_SAT = 4'hF;

  typedef struct packed {
    logic wr_en;
    logic [SYM_W-1:0] wr_sym;
    logic [LEN_W-1:0] len;
  } cell_ctrl_t;

endpackage

>>> rtl/core/kcl_cell.sv
// One entry slot of the keypad code lock: stores a symbol and extends the match chain.
// Depends on kcl_pkg.
module kcl_cell import kcl_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [SYM_W-1:0] code_nib,
  input  logic             match_in,
  output logic             match_out
);

  localparam logic [LEN_W-1:0] SLOT = LEN_W'(IDX);

  logic [SYM_W-1:0] sym;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.len == SLOT) begin
      sym <= ctrl.wr_sym;
    end
  end

  // slots at or beyond the entry length do not take part
  assign match_out = match_in && (ctrl.len <= SLOT || sym == code_nib);

endmodule

>>> rtl/core/keypad_code_lock.sv
// Keypad code lock top level: byte decode, lock state, row of entry cells, output register.
// The result is registered and becomes valid on m_axis in the cycle after the input transfer.
// Throughput: one byte per cycle while m_axis is not stalled; the compare is a chain through all entry cells.
// Reset (rst, synchronous, active high) clears lock state, output valid and the
// configuration registers to their defaults; entry slots are not cleared.
// Depends on kcl_pkg, kcl_cell and keypad_code_lock_defines.svh.
`include "keypad_code_lock_defines.svh"

module keypad_code_lock import kcl_pkg::*; #(
  parameter int MAX_SYMBOLS = KCL_MAX_SYMBOLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // [2:0] event_res, [3] door_open,
                                           // [4] alarm, [9:5] entry_count
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CODE_W-1:0] cfg_data
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SYMBOLS);
  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_SYMBOLS + 1);

  logic [CODE_W-1:0] code_q;
  logic [LEN_W-1:0]  code_len_q;
  logic [3:0]        limit_q;

  logic [LEN_W-1:0]  len_q, len_next;
  logic [3:0]        fail_q, fail_next, fail_inc;
  logic              alarm_q, alarm_next;
  logic              door_q, door_next;
  logic [2:0]        ev;

  logic              accept;
  logic              is_submit, is_clear, is_sym, match;
  logic [7:0]        sym_off;
  cell_ctrl_t        ctrl;
  logic              chain [0:MAX_SYMBOLS];

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_q <= CODE_RESET;
      code_len_q <= CODE_LENGTH_RESET;
      limit_q <= FAILURE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_SYMBOLS:  code_q <= cfg_data;
        REG_CODE_LENGTH:   code_len_q <= cfg_data[LEN_W-1:0];
        REG_FAILURE_LIMIT: limit_q <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign is_submit = s_axis_tdata == CH_SUBMIT;
  assign is_clear = s_axis_tdata == CH_CLEAR;
  assign is_sym = s_axis_tdata >= SYM_LOW && s_axis_tdata <= SYM_HIGH;
  assign sym_off = s_axis_tdata - SYM_LOW;

  assign ctrl.wr_en = accept && !door_q && is_sym && len_q < LEN_MAX;
  assign ctrl.wr_sym = sym_off[SYM_W-1:0];
  assign ctrl.len = len_q;

  assign chain[0] = 1'b1;

  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
    kcl_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .code_nib  (code_q[SYM_W*i +: SYM_W]),
      .match_in  (chain[i]),
      .match_out (chain[i+1])
    );
  end

  assign match = chain[MAX_SYMBOLS] && len_q == code_len_q && len_q <= LEN_MAX;
  assign fail_inc = (fail_q == FAIL_SAT) ? FAIL_SAT : fail_q + 4'd1;

  always_comb begin
    len_next = len_q;
    fail_next = fail_q;
    alarm_next = alarm_q;
    door_next = door_q;
    ev = EV_IGNORED;
    if (!door_q) begin
      if (is_submit) begin
        if (match) begin
          door_next = 1'b1;
          alarm_next = 1'b0;
          ev = EV_OPENED;
        end else begin
          fail_next = fail_inc;
          if (fail_inc >= limit_q) begin
            alarm_next = 1'b1;
          end
          len_next = '0;
          ev = EV_WRONG;
        end
      end else if (is_clear) begin
        len_next = '0;
        ev = EV_CLEARED;
      end else if (is_sym) begin
        len_next = (len_q < LEN_MAX) ? len_q + LEN_W'(1) : LEN_SAT;
        ev = EV_SYMBOL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_q <= '0;
      fail_q <= '0;
      alarm_q <= 1'b0;
      door_q <= 1'b0;
    end else if (accept) begin
      len_q <= len_next;
      fail_q <= fail_next;
      alarm_q <= alarm_next;
      door_q <= door_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {6'd0, len_next, alarm_next, door_next, ev};
    end
  end

  `KCL_ASSERT_NEXT(a_door_sticks, door_q, door_q, "door closed again after opening")
  `KCL_ASSERT_NEXT(a_open_freezes_entry, door_q, $stable(len_q), "entry changed while open")
  `KCL_ASSERT_IMPL(a_len_bound, 1'b1, len_q <= LEN_SAT, "entry length beyond saturation")
  `KCL_ASSERT_IMPL(a_no_alarm_when_open, m_axis_tvalid && m_axis_tdata[3],
                   !m_axis_tdata[4], "alarm shown with door open")

endmodule
